// ===== hdl/bnce_pkg.sv =====
// Package for the baseline noise cut estimator: widths, scale constant,
// controller states and the command/status structs.
// No dependencies.
`default_nettype none

package bnce_pkg;

    // Field and state widths
    localparam int SAMPLE_WIDTH   = 32;
    localparam int FRACTION_BITS  = 8;
    localparam int SUM_WIDTH      = 48;
    localparam int COUNT_WIDTH    = 16;
    localparam int CUT_WIDTH      = 32;

    // Pair test widths: difference magnitude and ten times a sample
    localparam int DIFF_WIDTH     = SAMPLE_WIDTH + 1;
    localparam int TEN_WIDTH      = SAMPLE_WIDTH + 5;

    // 8*sqrt(pi/2) as unsigned Q24
    localparam int SCALE_WIDTH    = 28;
    localparam logic [SCALE_WIDTH-1:0] SCALE_Q24 = 28'd168216976;

    // Sum is split into two halves for the scale multiply
    localparam int SPLIT          = 24;
    localparam int PROD_WIDTH     = (SUM_WIDTH - SPLIT) + SCALE_WIDTH;
    localparam int DIVIDEND_WIDTH = PROD_WIDTH + 1 - FRACTION_BITS;
    localparam int STEP_WIDTH     = $clog2(DIVIDEND_WIDTH);

    localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = {SUM_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Controller states
    typedef enum logic [2:0] {
        ST_RUN,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // input transaction taken
        logic capture;   // accepted item is last: snapshot and clear totals
        logic mul;       // register the two scale products
        logic load_div;  // load dividend, clear remainder and step count
        logic div_step;  // one restoring division step
        logic finish;    // load output registers
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_last;  // current division step is the final one
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/bnce_ctrl.sv =====
// Controller for the baseline noise cut estimator: sequences accumulation,
// scale multiply, bit-serial division and result hand-off.
// Depends on bnce_pkg.
`default_nettype none

module bnce_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    input  wire logic              i_out_ready,
    input  wire bnce_pkg::t_status i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output bnce_pkg::t_cmd         o_cmd
);

    bnce_pkg::t_state r_state;
    bnce_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bnce_pkg::ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            bnce_pkg::ST_RUN: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    o_cmd.capture = 1'b1;
                    n_state       = bnce_pkg::ST_MUL;
                end
            end
            bnce_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = bnce_pkg::ST_ADD;
            end
            bnce_pkg::ST_ADD: begin
                o_cmd.load_div = 1'b1;
                n_state        = bnce_pkg::ST_DIV;
            end
            bnce_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = bnce_pkg::ST_FIN;
                end
            end
            bnce_pkg::ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = bnce_pkg::ST_OUT;
            end
            bnce_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = bnce_pkg::ST_RUN;
                end
            end
            default: begin
                n_state = bnce_pkg::ST_RUN;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/bnce_dpath.sv =====
// Datapath for the baseline noise cut estimator: pair test and saturating
// accumulation, scale multiply, restoring divider and output registers.
// Depends on bnce_pkg.
`default_nettype none

module bnce_dpath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire bnce_pkg::t_cmd                       i_cmd,
    input  wire logic signed [bnce_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                                 i_group_start,
    output bnce_pkg::t_status                         o_status,
    output logic [bnce_pkg::CUT_WIDTH-1:0]            o_cut,
    output logic [bnce_pkg::COUNT_WIDTH-1:0]          o_pairs_used
);

    // Pairing and totals
    logic signed [bnce_pkg::SAMPLE_WIDTH-1:0] r_prev;
    logic                                     r_prev_valid;
    logic [bnce_pkg::SUM_WIDTH-1:0]           r_sum;
    logic [bnce_pkg::COUNT_WIDTH-1:0]         r_count;

    // Snapshot, products, divider, outputs
    logic [bnce_pkg::SUM_WIDTH-1:0]           r_snap_sum;
    logic [bnce_pkg::COUNT_WIDTH-1:0]         r_snap_count;
    logic [bnce_pkg::PROD_WIDTH-1:0]          r_prod_hi;
    logic [bnce_pkg::PROD_WIDTH-1:0]          r_prod_lo;
    logic [bnce_pkg::DIVIDEND_WIDTH-1:0]      r_quot;
    logic [bnce_pkg::COUNT_WIDTH-1:0]         r_rem;
    logic [bnce_pkg::STEP_WIDTH-1:0]          r_step;
    logic [bnce_pkg::CUT_WIDTH-1:0]           r_cut;
    logic [bnce_pkg::COUNT_WIDTH-1:0]         r_pairs;

    logic signed [bnce_pkg::DIFF_WIDTH-1:0]   diff;
    logic [bnce_pkg::DIFF_WIDTH-1:0]          mag;
    logic signed [bnce_pkg::TEN_WIDTH-1:0]    ten_a;
    logic signed [bnce_pkg::TEN_WIDTH-1:0]    ten_b;
    logic signed [bnce_pkg::TEN_WIDTH-1:0]    mag_s;
    logic                                     keep;
    logic [bnce_pkg::SUM_WIDTH:0]             sum_wide;
    logic [bnce_pkg::SUM_WIDTH-1:0]           n_sum;
    logic [bnce_pkg::COUNT_WIDTH-1:0]         n_count;
    logic [bnce_pkg::PROD_WIDTH:0]            scaled;
    logic [bnce_pkg::COUNT_WIDTH:0]           trial;
    logic [bnce_pkg::COUNT_WIDTH:0]           trial_sub;
    logic                                     trial_ge;
    logic                                     quot_over;

    // Pair test: magnitude nonzero and below ten times each sample
    always_comb begin
        diff  = bnce_pkg::DIFF_WIDTH'(r_prev) - bnce_pkg::DIFF_WIDTH'(i_sample);
        mag   = diff[bnce_pkg::DIFF_WIDTH-1] ? bnce_pkg::DIFF_WIDTH'(-diff)
                                             : bnce_pkg::DIFF_WIDTH'(diff);
        ten_a = (bnce_pkg::TEN_WIDTH'(r_prev) <<< 3) + (bnce_pkg::TEN_WIDTH'(r_prev) <<< 1);
        ten_b = (bnce_pkg::TEN_WIDTH'(i_sample) <<< 3)
              + (bnce_pkg::TEN_WIDTH'(i_sample) <<< 1);
        mag_s = $signed(bnce_pkg::TEN_WIDTH'(mag));
        keep  = r_prev_valid && !i_group_start && (mag != '0)
             && (mag_s < ten_a) && (mag_s < ten_b);
    end

    // Saturating totals
    always_comb begin
        sum_wide = (bnce_pkg::SUM_WIDTH+1)'(r_sum) + (bnce_pkg::SUM_WIDTH+1)'(mag);
        n_sum    = r_sum;
        n_count  = r_count;
        if (keep) begin
            n_sum = sum_wide[bnce_pkg::SUM_WIDTH] ? bnce_pkg::SUM_MAX
                                                  : sum_wide[bnce_pkg::SUM_WIDTH-1:0];
            if (r_count != bnce_pkg::COUNT_MAX) begin
                n_count = r_count + bnce_pkg::COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_sum        <= '0;
            r_count      <= '0;
        end else if (i_cmd.accept) begin
            r_prev       <= i_sample;
            r_prev_valid <= 1'b1;
            if (i_cmd.capture) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
        end
    end

    // Snapshot of the totals including the last item's pair
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_snap_sum   <= n_sum;
            r_snap_count <= n_count;
        end
    end

    // Scale products, one per half of the sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_hi <= bnce_pkg::PROD_WIDTH'(r_snap_sum[bnce_pkg::SUM_WIDTH-1:bnce_pkg::SPLIT])
                       * bnce_pkg::PROD_WIDTH'(bnce_pkg::SCALE_Q24);
            r_prod_lo <= bnce_pkg::PROD_WIDTH'(r_snap_sum[bnce_pkg::SPLIT-1:0])
                       * bnce_pkg::PROD_WIDTH'(bnce_pkg::SCALE_Q24);
        end
    end

    assign scaled = (bnce_pkg::PROD_WIDTH+1)'(r_prod_hi)
                  + (bnce_pkg::PROD_WIDTH+1)'(r_prod_lo >> bnce_pkg::SPLIT);

    // Restoring division step, one quotient bit per cycle
    always_comb begin
        trial     = {r_rem, r_quot[bnce_pkg::DIVIDEND_WIDTH-1]};
        trial_sub = trial - {1'b0, r_snap_count};
        trial_ge  = trial >= {1'b0, r_snap_count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.load_div) begin
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + bnce_pkg::STEP_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_quot <= bnce_pkg::DIVIDEND_WIDTH'(scaled >> bnce_pkg::FRACTION_BITS);
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[bnce_pkg::DIVIDEND_WIDTH-2:0], trial_ge};
            r_rem  <= trial_ge ? trial_sub[bnce_pkg::COUNT_WIDTH-1:0]
                               : trial[bnce_pkg::COUNT_WIDTH-1:0];
        end
    end

    assign o_status.div_last = (r_step == bnce_pkg::STEP_WIDTH'(bnce_pkg::DIVIDEND_WIDTH - 1));

    // Output registers: zero when nothing kept, saturate at the cut width
    assign quot_over = |r_quot[bnce_pkg::DIVIDEND_WIDTH-1:bnce_pkg::CUT_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_pairs <= r_snap_count;
            if (r_snap_count == '0) begin
                r_cut <= '0;
            end else if (quot_over) begin
                r_cut <= '1;
            end else begin
                r_cut <= r_quot[bnce_pkg::CUT_WIDTH-1:0];
            end
        end
    end

    assign o_cut        = r_cut;
    assign o_pairs_used = r_pairs;

endmodule

`default_nettype wire

// ===== hdl/baseline_noise_cut_estimator_core.sv =====
// Baseline noise cut estimator, top level: controller plus datapath.
// Depends on bnce_pkg, bnce_ctrl and bnce_dpath.
//
// Usage:
//   Input channel (i_valid/o_ready) carries i_sample (signed, 8 fraction
//   bits), i_group_start and i_last. A sample with group start set pairs with
//   nothing. Items without last are taken one per cycle, back to back.
//   An item with last closes the data set: the block stops taking input,
//   forms 8*sqrt(pi/2)*sum/count and presents o_cut and o_pairs_used on the
//   output channel (o_valid/i_ready).
//   From the last item to o_valid the block passes through the product register,
//   the dividend load, one quotient bit per cycle over the 45-bit dividend in
//   the restoring divider, and the output load. While the result waits,
//   o_ready stays low; a stalled receiver therefore holds the input side
//   too. Once the result is taken, input resumes the next cycle.
//   Reset (synchronous, active low) clears the previous sample, the totals
//   and the controller; no result is pending afterwards.
`default_nettype none

module baseline_noise_cut_estimator_core (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_valid,
    output logic                                          o_ready,
    input  wire logic signed [bnce_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                                     i_group_start,
    input  wire logic                                     i_last,
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output logic [bnce_pkg::CUT_WIDTH-1:0]                o_cut,
    output logic [bnce_pkg::COUNT_WIDTH-1:0]              o_pairs_used
);

    bnce_pkg::t_cmd    cmd;
    bnce_pkg::t_status status;

    // Sequencer
    bnce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_last   (i_last),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    // Arithmetic
    bnce_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_sample      (i_sample),
        .i_group_start (i_group_start),
        .o_status      (status),
        .o_cut         (o_cut),
        .o_pairs_used  (o_pairs_used)
    );

`ifndef SYNTH
    // No new input while a result is pending
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while result pending");

    // A last item stops further input on the next cycle
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last) |=> !o_ready)
        else $error("input not blocked after last item");

    // Nothing kept gives a zero cut
    a_zero_count_zero_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_pairs_used == '0)) |-> (o_cut == '0))
        else $error("nonzero cut with no pairs");
`endif

endmodule

`default_nettype wire
